// File: hw/rtl/pisl_pkg.sv
// shared types and constants for the incremental pi speed loop
package pisl_pkg;

    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int DRIVE_W = 16;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 2;

    localparam logic [INDEX_W-1:0] REG_PROP_GAIN   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_INTEG_GAIN  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_DRIVE_LIMIT = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7fff;

    // sign of the error, carried alongside the products
    typedef struct packed {
        logic pos;
        logic neg;
    } pisl_dir_t;

endpackage

// File: hw/rtl/pisl_prod.sv
// error, error change and both gain products, registered
module pisl_prod #(
    parameter int SPEED_WIDTH = 16,
    parameter int PP_W        = 35,
    parameter int PI_W        = 34
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SPEED_WIDTH-1:0]   s_target_speed,
    input  logic signed [SPEED_WIDTH-1:0]   s_measured_speed,
    input  logic [pisl_pkg::GAIN_W-1:0]     prop_gain,
    input  logic [pisl_pkg::GAIN_W-1:0]     integ_gain,
    input  logic                            dn_ready,
    output logic                            dn_valid,
    output logic signed [PP_W-1:0]          prod_p,
    output logic signed [PI_W-1:0]          prod_i,
    output pisl_pkg::pisl_dir_t             dir
);

    localparam int ERR_W  = SPEED_WIDTH + 1;
    localparam int DERR_W = SPEED_WIDTH + 2;

    logic                      valid_reg, valid_next;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [PP_W-1:0]    prod_p_reg, prod_p_next;
    logic signed [PI_W-1:0]    prod_i_reg, prod_i_next;
    pisl_pkg::pisl_dir_t       dir_reg, dir_next;

    logic                      in_fire;
    logic signed [ERR_W-1:0]   err;
    logic signed [DERR_W-1:0]  derr;
    logic signed [pisl_pkg::GAIN_W:0] kp_s, ki_s;

    assign s_ready = !valid_reg || dn_ready;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        err  = ERR_W'(s_target_speed) - ERR_W'(s_measured_speed);
        derr = DERR_W'(err) - DERR_W'(prev_err_reg);
        kp_s = {1'b0, prop_gain};
        ki_s = {1'b0, integ_gain};
        prod_p_next  = kp_s * derr;
        prod_i_next  = ki_s * err;
        dir_next.pos = !err[ERR_W-1] && (err != '0);
        dir_next.neg = err[ERR_W-1];
        if (in_fire) begin
            valid_next = 1'b1;
        end else if (dn_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            prev_err_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            if (in_fire) begin
                prev_err_reg <= err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            dir_reg    <= dir_next;
        end
    end

    assign dn_valid = valid_reg;
    assign prod_p   = prod_p_reg;
    assign prod_i   = prod_i_reg;
    assign dir      = dir_reg;

endmodule

// File: hw/rtl/pisl_accum.sv
// accumulator update with conditional integration, clamp and result register
module pisl_accum #(
    parameter int FRACTION_BITS = 8,
    parameter int PP_W          = 35,
    parameter int PI_W          = 34
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic signed [PP_W-1:0]            prod_p,
    input  logic signed [PI_W-1:0]            prod_i,
    input  pisl_pkg::pisl_dir_t               dir,
    input  logic [pisl_pkg::LIMIT_W-1:0]      drive_limit,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pisl_pkg::DRIVE_W-1:0] m_drive,
    output logic                              m_integral_held,
    output logic                              m_saturated
);

    localparam int ACC_W  = pisl_pkg::LIMIT_W + FRACTION_BITS + 1;
    localparam int BIG_W  = (PP_W > ACC_W) ? PP_W : ACC_W;
    localparam int SUM_W  = BIG_W + 2;
    localparam logic [ACC_W-1:0] BIAS = ACC_W'((64'd1 << FRACTION_BITS) - 64'd1);

    logic                          valid_reg, valid_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [pisl_pkg::DRIVE_W-1:0] drive_reg, drive_next;
    logic                          held_reg, held_next;
    logic                          sat_reg, sat_next;

    logic                          load, step;
    logic signed [ACC_W-1:0]       lim, neg_lim, acc_adj;
    logic signed [SUM_W-1:0]       sum, integ_term;

    assign load     = !valid_reg || m_ready;
    assign step     = load && up_valid;
    assign up_ready = load;

    always_comb begin
        lim     = {1'b0, drive_limit, {FRACTION_BITS{1'b0}}};
        neg_lim = -lim;
        // integral term is dropped when already at a limit and the error pushes outward
        held_next = (acc_reg >= lim && dir.pos) || (acc_reg <= neg_lim && dir.neg);
        integ_term = held_next ? '0 : SUM_W'(prod_i);
        sum = SUM_W'(acc_reg) + SUM_W'(prod_p) + integ_term;
        sat_next = 1'b1;
        if (sum > SUM_W'(lim)) begin
            acc_next = lim;
        end else if (sum < SUM_W'(neg_lim)) begin
            acc_next = neg_lim;
        end else begin
            acc_next = sum[ACC_W-1:0];
            sat_next = 1'b0;
        end
        // truncate toward zero
        acc_adj    = acc_next[ACC_W-1] ? (acc_next + BIAS) : acc_next;
        drive_next = acc_adj[ACC_W-1:FRACTION_BITS];
        valid_next = load ? up_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            if (step) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            drive_reg <= drive_next;
            held_reg  <= held_next;
            sat_reg   <= sat_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_drive         = drive_reg;
    assign m_integral_held = held_reg;
    assign m_saturated     = sat_reg;

endmodule

// File: hw/rtl/incremental_pi_speed_loop_antiwindup.sv
// Incremental PI wheel-speed regulator with conditional-integration anti-windup.
//
// Input channel (s_valid/s_ready) carries one beat per control tick: target and
// measured speed in whole encoder counts. Result channel (m_valid/m_ready) returns
// one beat per input beat: the drive value, an integral-held flag and a clamp flag.
// The user is to write gains and the drive limit via cfg_wr_en/cfg_index/cfg_wdata
// only while the block is idle, not enforced here; an unknown index is ignored.
//
// From input acceptance, a beat passes through one register stage for the error and
// both gain products, then the accumulator update, clamp and result register. A
// new beat is accepted every cycle while neither stage is stalled; the
// accumulator feedback closes in the second stage, which sets the rate.
//
// Reset clears gains to zero, the limit to full scale, the previous error and the
// accumulator to zero, and empties both stages. When the receiver stalls, the
// result register holds its beat and the product stage keeps one more; after
// that s_ready drops until m_ready returns.
module incremental_pi_speed_loop_antiwindup #(
    parameter int FRACTION_BITS = 8,
    parameter int SPEED_WIDTH   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pisl_pkg::INDEX_W-1:0]        cfg_index,
    input  logic [pisl_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SPEED_WIDTH-1:0]       s_target_speed,
    input  logic signed [SPEED_WIDTH-1:0]       s_measured_speed,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pisl_pkg::DRIVE_W-1:0] m_drive,
    output logic                                m_integral_held,
    output logic                                m_saturated
);

    localparam int PP_W = pisl_pkg::GAIN_W + 1 + SPEED_WIDTH + 2;
    localparam int PI_W = pisl_pkg::GAIN_W + 1 + SPEED_WIDTH + 1;

    logic [pisl_pkg::GAIN_W-1:0]  prop_gain_reg;
    logic [pisl_pkg::GAIN_W-1:0]  integ_gain_reg;
    logic [pisl_pkg::LIMIT_W-1:0] drive_limit_reg;

    logic                         mid_valid, mid_ready;
    logic signed [PP_W-1:0]       prod_p;
    logic signed [PI_W-1:0]       prod_i;
    pisl_pkg::pisl_dir_t          dir;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            drive_limit_reg <= pisl_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pisl_pkg::REG_PROP_GAIN: begin
                    prop_gain_reg <= cfg_wdata;
                end
                pisl_pkg::REG_INTEG_GAIN: begin
                    integ_gain_reg <= cfg_wdata;
                end
                pisl_pkg::REG_DRIVE_LIMIT: begin
                    drive_limit_reg <= cfg_wdata[pisl_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pisl_prod #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .PP_W        (PP_W),
        .PI_W        (PI_W)
    ) u_prod (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_target_speed   (s_target_speed),
        .s_measured_speed (s_measured_speed),
        .prop_gain        (prop_gain_reg),
        .integ_gain       (integ_gain_reg),
        .dn_ready         (mid_ready),
        .dn_valid         (mid_valid),
        .prod_p           (prod_p),
        .prod_i           (prod_i),
        .dir              (dir)
    );

    pisl_accum #(
        .FRACTION_BITS (FRACTION_BITS),
        .PP_W          (PP_W),
        .PI_W          (PI_W)
    ) u_accum (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .up_valid        (mid_valid),
        .up_ready        (mid_ready),
        .prod_p          (prod_p),
        .prod_i          (prod_i),
        .dir             (dir),
        .drive_limit     (drive_limit_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive         (m_drive),
        .m_integral_held (m_integral_held),
        .m_saturated     (m_saturated)
    );

endmodule
